>>> hw/rtl/srs_pkg.sv
// Package for the server route selector: payload types, status and kind codes.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package srs_pkg;

    localparam int NUM_TYPES_DEF = 8;
    localparam int MAX_SLOTS_DEF = 64;
    localparam int CFG_W = 7;
    localparam int ID_W = 6;
    localparam int TYPE_W = 4;

    localparam logic [1:0] KIND_REG = 2'd0;
    localparam logic [1:0] KIND_DISC = 2'd1;
    localparam logic [1:0] KIND_XFER = 2'd2;
    localparam logic [1:0] KIND_IGNORE = 2'd3;

    localparam logic [2:0] MODE_ID = 3'd0;
    localparam logic [2:0] MODE_HASH = 3'd1;
    localparam logic [2:0] MODE_BCAST = 3'd2;
    localparam logic [2:0] MODE_RAND = 3'd3;
    localparam logic [2:0] MODE_REXC = 3'd4;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_TYPE = 3'd1;
    localparam logic [2:0] ST_ID = 3'd2;
    localparam logic [2:0] ST_NOCONN = 3'd3;
    localparam logic [2:0] ST_NODEST = 3'd4;
    localparam logic [2:0] ST_REPLACED = 3'd5;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  dest_type;
        logic [5:0]  dest_id;
        logic [2:0]  route_mode;
        logic [31:0] hash_key;
        logic [5:0]  random_start;
        logic [5:0]  excluded_id;
    } srs_in_t;

    typedef struct packed {
        logic [5:0] chosen_id;
        logic       delivered;
        logic [2:0] status;
        logic       last;
    } srs_out_t;

    // Item after classification, handed from the front part to the back part.
    typedef struct packed {
        srs_in_t    item;
        logic [6:0] cnt;
        logic       type_ok;
    } srs_cmd_t;

endpackage
`default_nettype wire

>>> hw/rtl/server_route_selector.sv
// Server route selector top level. Register, disconnect and by-id items are decided as
// soon as the back part takes them; hash keys are reduced one remainder bit per cycle;
// random items reduce their start offset and then scan slot by slot; broadcast items scan
// each slot up to the last registered slot. The back part holds one item at a time and
// takes the next once the previous has finished; a full output queue stalls it.
// Reset clears the slot counts, all marks and both queues.
`timescale 1ns / 1ps
`default_nettype none
module server_route_selector
    import srs_pkg::*;
#(
    parameter int NUM_TYPES = NUM_TYPES_DEF,
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire srs_in_t    in_item,
    input  wire logic       push,
    output logic            full,
    output srs_out_t        out_item,
    output logic            empty,
    input  wire logic       pop,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [2:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    logic [NUM_TYPES*CFG_W-1:0] slots_reg;
    srs_cmd_t cmd;
    logic     cmd_valid, cmd_take;

    assign cfg_ready = 1'b1;

    // Slot count registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= '0;
        end
        else if (cfg_valid && 32'(cfg_index) < NUM_TYPES)
        begin
            slots_reg[32'(cfg_index)*CFG_W +: CFG_W] <= cfg_data;
        end
    end

    srs_front #(.NUM_TYPES(NUM_TYPES), .MAX_SLOTS(MAX_SLOTS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_item(in_item), .push(push), .full(full),
        .slots(slots_reg), .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take)
    );

    srs_back #(.NUM_TYPES(NUM_TYPES), .MAX_SLOTS(MAX_SLOTS)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .cmd_valid(cmd_valid),
        .cmd_take(cmd_take), .res(out_item), .empty(empty), .pop(pop)
    );

endmodule
`default_nettype wire

>>> hw/rtl/srs_front.sv
// Front part: accepts items, drops kind three, looks up the slot count and
// queues classified items for the back part. Uses srs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module srs_front
    import srs_pkg::*;
#(
    parameter int NUM_TYPES = NUM_TYPES_DEF,
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire srs_in_t         in_item,
    input  wire logic            push,
    output logic                 full,
    input  wire logic [NUM_TYPES*CFG_W-1:0] slots,
    output srs_cmd_t             cmd,
    output logic                 cmd_valid,
    input  wire logic            cmd_take
);

    srs_cmd_t   q_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] n_reg;
    srs_cmd_t   c_next;
    logic [CFG_W-1:0] raw;
    logic       acc;

    // Classify the incoming item: type range and clamped slot count.
    always_comb
    begin
        c_next.item = in_item;
        c_next.type_ok = (32'(in_item.dest_type) < NUM_TYPES);
        raw = '0;
        for (int t = 0; t < NUM_TYPES; t++)
        begin
            if (32'(in_item.dest_type) == t)
            begin
                raw = slots[t*CFG_W +: CFG_W];
            end
        end
        c_next.cnt = (32'(raw) > MAX_SLOTS) ? 7'(MAX_SLOTS) : raw;
    end

    assign full = (n_reg == 2'd2);
    assign acc = push && !full && (in_item.kind != KIND_IGNORE);
    assign cmd_valid = (n_reg != 2'd0);
    assign cmd = q_reg[rp_reg];

    // Two-entry queue between the parts.
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            q_reg[wp_reg] <= c_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            n_reg <= 2'd0;
        end
        else
        begin
            if (acc)
            begin
                wp_reg <= !wp_reg;
            end
            if (cmd_take)
            begin
                rp_reg <= !rp_reg;
            end
            n_reg <= n_reg + {1'b0, acc} - {1'b0, cmd_take};
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/srs_back.sv
// Back part: holds the slot marks, reduces hash keys and random start offsets,
// scans slots and emits result items into a two-entry output queue. Uses srs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module srs_back
    import srs_pkg::*;
#(
    parameter int NUM_TYPES = NUM_TYPES_DEF,
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire srs_cmd_t cmd,
    input  wire logic     cmd_valid,
    output logic          cmd_take,
    output srs_out_t      res,
    output logic          empty,
    input  wire logic     pop
);

    localparam int TW = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_FALL = 3'd3;

    logic [MAX_SLOTS-1:0] regd_reg [NUM_TYPES];
    logic [MAX_SLOTS-1:0] conn_reg [NUM_TYPES];

    logic [2:0]  st_reg;
    srs_cmd_t    c_reg;
    logic [38:0] rem_reg;
    logic [5:0]  bit_reg;
    logic [6:0]  idx_reg;
    logic [6:0]  i_reg;
    logic        any_reg;

    srs_out_t    oq_reg [2];
    logic        owp_reg, orp_reg;
    logic [1:0]  on_reg;

    logic        emit;
    srs_out_t    e;
    logic        space;
    logic [TW-1:0] tt;
    logic [MAX_SLOTS-1:0] rrow, crow;
    logic [38:0] trial;
    logic        skip;
    logic [6:0]  idx_wrap;
    logic        more;

    assign space = (on_reg != 2'd2) || pop;
    assign empty = (on_reg == 2'd0);
    assign res = oq_reg[orp_reg];
    assign tt = c_reg.item.dest_type[TW-1:0];
    assign rrow = regd_reg[tt];
    assign crow = conn_reg[tt];
    assign trial = rem_reg - ({32'd0, c_reg.cnt} << bit_reg);
    assign skip = (c_reg.item.route_mode == MODE_REXC)
        && ({1'b0, c_reg.item.excluded_id} < c_reg.cnt);
    assign idx_wrap = (idx_reg + 7'd1 >= c_reg.cnt) ? 7'd0 : idx_reg + 7'd1;

    // Whether a registered slot lies above the scan index within the slot count.
    always_comb
    begin
        more = 1'b0;
        for (int k = 0; k < MAX_SLOTS; k++)
        begin
            if (rrow[k] && (k > 32'(idx_reg)) && (k < 32'(c_reg.cnt)))
            begin
                more = 1'b1;
            end
        end
    end

    // One result per cycle at most, decided by the sequencer state.
    always_comb
    begin
        emit = 1'b0;
        e = '0;
        cmd_take = 1'b0;
        if (st_reg == S_IDLE && cmd_valid && space)
        begin
            if (!cmd.type_ok)
            begin
                emit = 1'b1;
                e.chosen_id = (cmd.item.kind == KIND_XFER) ? 6'd0 : cmd.item.dest_id;
                e.status = ST_TYPE;
                e.last = 1'b1;
                cmd_take = 1'b1;
            end
            else if (cmd.item.kind != KIND_XFER || cmd.item.route_mode == MODE_ID)
            begin
                emit = 1'b1;
                e.chosen_id = cmd.item.dest_id;
                e.last = 1'b1;
                cmd_take = 1'b1;
                if ({1'b0, cmd.item.dest_id} >= cmd.cnt)
                begin
                    e.status = ST_ID;
                end
                else if (cmd.item.kind == KIND_REG)
                begin
                    e.status = conn_reg[cmd.item.dest_type[TW-1:0]][cmd.item.dest_id[$clog2(MAX_SLOTS > 1 ? MAX_SLOTS : 2)-1:0]]
                        ? ST_REPLACED : ST_OK;
                end
                else if (cmd.item.kind == KIND_DISC)
                begin
                    e.status = ST_OK;
                end
                else if (conn_reg[cmd.item.dest_type[TW-1:0]][cmd.item.dest_id[$clog2(MAX_SLOTS > 1 ? MAX_SLOTS : 2)-1:0]])
                begin
                    e.delivered = 1'b1;
                    e.status = ST_OK;
                end
                else
                begin
                    e.status = ST_NOCONN;
                end
            end
            else if (cmd.cnt == 7'd0 || cmd.item.route_mode > MODE_REXC)
            begin
                emit = 1'b1;
                e.status = ST_NODEST;
                e.last = 1'b1;
                cmd_take = 1'b1;
            end
            else
            begin
                cmd_take = 1'b1;
            end
        end
        else if (space && st_reg == S_MOD && bit_reg == 6'd0
                 && c_reg.item.route_mode == MODE_HASH)
        begin
            emit = 1'b1;
            e.chosen_id = trial[38] ? rem_reg[5:0] : trial[5:0];
            e.delivered = crow[e.chosen_id];
            e.status = e.delivered ? ST_OK : ST_NOCONN;
            e.last = 1'b1;
        end
        else if (space && st_reg == S_SCAN)
        begin
            if (c_reg.item.route_mode == MODE_BCAST)
            begin
                if (rrow[idx_reg[5:0]])
                begin
                    emit = 1'b1;
                    e.chosen_id = idx_reg[5:0];
                    e.delivered = crow[idx_reg[5:0]];
                    e.status = e.delivered ? ST_OK : ST_NOCONN;
                    e.last = !more;
                end
                else if (idx_reg + 7'd1 == c_reg.cnt && !any_reg)
                begin
                    emit = 1'b1;
                    e.status = ST_NODEST;
                    e.last = 1'b1;
                end
            end
            else if (rrow[idx_reg[5:0]] && !(skip && idx_reg[5:0] == c_reg.item.excluded_id))
            begin
                emit = 1'b1;
                e.chosen_id = idx_reg[5:0];
                e.delivered = crow[idx_reg[5:0]];
                e.status = e.delivered ? ST_OK : ST_NOCONN;
                e.last = 1'b1;
            end
        end
        else if (space && st_reg == S_FALL)
        begin
            emit = 1'b1;
            e.last = 1'b1;
            if (skip && rrow[c_reg.item.excluded_id])
            begin
                e.chosen_id = c_reg.item.excluded_id;
                e.delivered = crow[c_reg.item.excluded_id];
                e.status = e.delivered ? ST_OK : ST_NOCONN;
            end
            else
            begin
                e.status = ST_NODEST;
            end
        end
    end

    // Output queue: one result written, one popped per cycle.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            oq_reg[owp_reg] <= e;
        end
    end

    // Sequencer over the modulo reduction and the slot scan; also updates the slot marks and output queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            c_reg <= '0;
            rem_reg <= '0;
            bit_reg <= '0;
            idx_reg <= '0;
            i_reg <= '0;
            owp_reg <= 1'b0;
            orp_reg <= 1'b0;
            on_reg <= 2'd0;
            any_reg <= 1'b0;
            for (int t = 0; t < NUM_TYPES; t++)
            begin
                regd_reg[t] <= '0;
                conn_reg[t] <= '0;
            end
        end
        else
        begin
            if (emit)
            begin
                owp_reg <= !owp_reg;
            end
            if (pop && !empty)
            begin
                orp_reg <= !orp_reg;
            end
            on_reg <= on_reg + {1'b0, emit} - {1'b0, pop && !empty};
            case (st_reg)
                S_IDLE:
                begin
                    if (cmd_take)
                    begin
                        c_reg <= cmd;
                        any_reg <= 1'b0;
                        if (cmd.type_ok && cmd.item.kind != KIND_XFER
                            && {1'b0, cmd.item.dest_id} < cmd.cnt)
                        begin
                            if (cmd.item.kind == KIND_REG)
                            begin
                                regd_reg[cmd.item.dest_type[TW-1:0]][cmd.item.dest_id] <= 1'b1;
                                conn_reg[cmd.item.dest_type[TW-1:0]][cmd.item.dest_id] <= 1'b1;
                            end
                            else
                            begin
                                conn_reg[cmd.item.dest_type[TW-1:0]][cmd.item.dest_id] <= 1'b0;
                            end
                        end
                        if (!emit)
                        begin
                            idx_reg <= 7'd0;
                            i_reg <= 7'd0;
                            if (cmd.item.route_mode == MODE_BCAST)
                            begin
                                st_reg <= S_SCAN;
                            end
                            else
                            begin
                                // Hash keys and random start offsets share the reduction.
                                st_reg <= S_MOD;
                                if (cmd.item.route_mode == MODE_HASH)
                                begin
                                    rem_reg <= {7'd0, cmd.item.hash_key};
                                    bit_reg <= 6'd32;
                                end
                                else
                                begin
                                    rem_reg <= {33'd0, cmd.item.random_start};
                                    bit_reg <= 6'd6;
                                end
                            end
                        end
                    end
                end
                S_MOD:
                begin
                    if (bit_reg != 6'd0)
                    begin
                        if (!trial[38])
                        begin
                            rem_reg <= trial;
                        end
                        bit_reg <= bit_reg - 6'd1;
                    end
                    else if (c_reg.item.route_mode != MODE_HASH)
                    begin
                        idx_reg <= trial[38] ? rem_reg[6:0] : trial[6:0];
                        st_reg <= S_SCAN;
                    end
                    else if (emit)
                    begin
                        st_reg <= S_IDLE;
                    end
                end
                S_SCAN:
                begin
                    if (c_reg.item.route_mode == MODE_BCAST)
                    begin
                        if (space)
                        begin
                            if (rrow[idx_reg[5:0]])
                            begin
                                any_reg <= 1'b1;
                            end
                            idx_reg <= idx_reg + 7'd1;
                            if (idx_reg + 7'd1 == c_reg.cnt || (rrow[idx_reg[5:0]] && !more))
                            begin
                                st_reg <= S_IDLE;
                            end
                        end
                    end
                    else if (emit)
                    begin
                        st_reg <= S_IDLE;
                    end
                    else if (space || !(rrow[idx_reg[5:0]]))
                    begin
                        idx_reg <= idx_wrap;
                        i_reg <= i_reg + 7'd1;
                        if (i_reg + 7'd1 == c_reg.cnt)
                        begin
                            st_reg <= S_FALL;
                        end
                    end
                end
                S_FALL:
                begin
                    if (emit)
                    begin
                        st_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire
